/* sv/tfc_pkg.sv */
`timescale 1ns / 1ps

package tfc_pkg;

   // Sensor raster geometry
   localparam int SensorColumns = 32;
   localparam int SensorRows    = 24;

   // Field and register widths
   localparam int TempW    = 16;
   localparam int CountW   = 5;
   localparam int PosW     = 10;
   localparam int BrightW  = 9;
   localparam int BlockW   = 5;
   localparam int ScreenW  = 10;
   localparam int ColorW   = 8;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   // Divider: dividend is d * 7 * 256, quotient is Q8 palette position below 7.0
   localparam int QuotW    = 11;
   localparam int DivisorW = 16;
   localparam int NumW     = DivisorW + QuotW;
   localparam int DivCntW  = $clog2(QuotW);
   localparam int SegW     = 3;
   localparam int BlendW   = 8;
   localparam int MixW     = 16;
   localparam int ProdW    = MixW + BrightW;

   // Register reset values
   localparam logic signed [TempW-1:0] TempLowReset    = 16'sd1152;
   localparam logic signed [TempW-1:0] TempHighReset   = 16'sd2432;
   localparam logic [BrightW-1:0]      BrightnessReset = 9'd128;
   localparam logic [BlockW-1:0]       BlockWidthReset = 5'd7;
   localparam logic [BlockW-1:0]       BlockHeightReset = 5'd5;
   localparam logic [ScreenW-1:0]      ScreenWidthReset = 10'd240;

   localparam logic signed [TempW-1:0] TempMin = 16'sh8000;
   localparam logic signed [TempW-1:0] TempMax = 16'sh7FFF;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_TEMP_LOW,
      CSR_TEMP_HIGH,
      CSR_BRIGHTNESS,
      CSR_BLOCK_WIDTH,
      CSR_BLOCK_HEIGHT,
      CSR_SCREEN_WIDTH
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MIX,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      COMP_RED,
      COMP_GREEN,
      COMP_BLUE
   } comp_type;

   // Display geometry taken from the configuration registers
   typedef struct packed {
      logic [BlockW-1:0]  cols_per_pixel;
      logic [BlockW-1:0]  rows_per_pixel;
      logic [ScreenW-1:0] screen_width;
   } tfc_geom_type;

   // Placement and frame extreme fields of one result
   typedef struct packed {
      logic [PosW-1:0]         block_x;
      logic [PosW-1:0]         block_y;
      logic                    frame_done;
      logic signed [TempW-1:0] hot_temp;
      logic [PosW-1:0]         hot_x;
      logic [PosW-1:0]         hot_y;
      logic signed [TempW-1:0] cold_temp;
      logic [PosW-1:0]         cold_x;
      logic [PosW-1:0]         cold_y;
   } tfc_place_type;

   // Palette entries as {red, green, blue} on/off bits (on means 255)
   localparam logic [2:0] Palette [8] = '{
      3'b000, 3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b101, 3'b111
   };

   function automatic logic tfc_pal_on(input logic [SegW-1:0] seg, input logic [1:0] comp);
      logic [2:0] entry;
      entry = Palette[seg];
      case (comp)
         COMP_RED:   return entry[2];
         COMP_GREEN: return entry[1];
         default:    return entry[0];
      endcase
   endfunction

   // screen_width - (col + 1) * cols_per_pixel
   function automatic logic signed [12:0] tfc_mirror(input logic [CountW-1:0] col,
                                                     input tfc_geom_type geom);
      logic [10:0] prod;
      prod = 11'({1'b0, col} + 6'd1) * 11'(geom.cols_per_pixel);
      return $signed({3'b000, geom.screen_width}) - $signed({2'b00, prod});
   endfunction

   function automatic logic [PosW-1:0] tfc_clamp10(input logic signed [12:0] v);
      if (v < 0) begin
         return '0;
      end else if (v > 13'sd1023) begin
         return 10'd1023;
      end
      return v[PosW-1:0];
   endfunction

endpackage

/* sv/tfc_req_if.sv */
`timescale 1ns / 1ps

interface tfc_req_if import tfc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [TempW-1:0] temperature;

   modport source (output valid, output temperature, input ready);
   modport sink (input valid, input temperature, output ready);
endinterface

/* sv/tfc_rsp_if.sv */
`timescale 1ns / 1ps

interface tfc_rsp_if import tfc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ColorW-1:0]       red;
   logic [ColorW-1:0]       green;
   logic [ColorW-1:0]       blue;
   logic [PosW-1:0]         block_x;
   logic [PosW-1:0]         block_y;
   logic                    frame_done;
   logic signed [TempW-1:0] hot_temp;
   logic [PosW-1:0]         hot_x;
   logic [PosW-1:0]         hot_y;
   logic signed [TempW-1:0] cold_temp;
   logic [PosW-1:0]         cold_x;
   logic [PosW-1:0]         cold_y;

   modport source (output valid, output red, output green, output blue, output block_x,
                   output block_y, output frame_done, output hot_temp, output hot_x,
                   output hot_y, output cold_temp, output cold_x, output cold_y,
                   input ready);
   modport sink (input valid, input red, input green, input blue, input block_x,
                 input block_y, input frame_done, input hot_temp, input hot_x,
                 input hot_y, input cold_temp, input cold_x, input cold_y,
                 output ready);
endinterface

/* sv/tfc_divider.sv */
`timescale 1ns / 1ps

module tfc_divider import tfc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NumW-1:0]     dividend,
   input  logic [DivisorW-1:0] divisor,
   output logic                done,
   output logic [QuotW-1:0]    quotient
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DivCntW-1:0]  count_ff, count_in;
   logic [DivisorW-1:0] rem_ff, rem_in;
   logic [DivisorW-1:0] divisor_ff, divisor_in;
   logic [QuotW-1:0]    shift_ff, shift_in;

   logic [DivisorW:0]   trial;
   logic                fits;

   // One restoring step per cycle; quotient bits shift in behind the dividend bits
   always_comb begin
      trial      = {rem_ff, shift_ff[QuotW-1]};
      fits       = trial >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      shift_in   = shift_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = dividend[NumW-1:QuotW];
         shift_in   = dividend[QuotW-1:0];
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? DivisorW'(trial - {1'b0, divisor_ff}) : trial[DivisorW-1:0];
         shift_in = {shift_ff[QuotW-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == DivCntW'(QuotW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      shift_ff   <= shift_in;
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

/* sv/tfc_tracker.sv */
`timescale 1ns / 1ps

module tfc_tracker import tfc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic signed [TempW-1:0] temperature,
   input  tfc_geom_type            geom,
   output tfc_place_type           place
);

   logic [CountW-1:0]       col_ff, col_in;
   logic [CountW-1:0]       row_ff, row_in;
   logic signed [TempW-1:0] hot_val_ff, hot_val_in;
   logic [CountW-1:0]       hot_col_ff, hot_col_in;
   logic [CountW-1:0]       hot_row_ff, hot_row_in;
   logic signed [TempW-1:0] cold_val_ff, cold_val_in;
   logic [CountW-1:0]       cold_col_ff, cold_col_in;
   logic [CountW-1:0]       cold_row_ff, cold_row_in;
   tfc_place_type           place_ff, place_in;

   logic                    col_last, row_last, frame_end;
   logic signed [TempW-1:0] hv, cv;
   logic [CountW-1:0]       hc, hr, cc, cr;
   logic signed [12:0]      half_w;
   logic [PosW-1:0]         half_h;

   // Count the current sample in, then report extremes on the frame's last sample
   always_comb begin
      col_last  = ({1'b0, col_ff} + 6'd1) >= 6'(SensorColumns);
      row_last  = ({1'b0, row_ff} + 6'd1) >= 6'(SensorRows);
      frame_end = col_last && row_last;
      half_w    = $signed(13'(geom.cols_per_pixel >> 1));
      half_h    = PosW'(geom.rows_per_pixel >> 1);

      hv = hot_val_ff;
      hc = hot_col_ff;
      hr = hot_row_ff;
      if (temperature > hot_val_ff) begin
         hv = temperature;
         hc = col_ff;
         hr = row_ff;
      end
      cv = cold_val_ff;
      cc = cold_col_ff;
      cr = cold_row_ff;
      if (temperature < cold_val_ff) begin
         cv = temperature;
         cc = col_ff;
         cr = row_ff;
      end

      place_in            = '0;
      place_in.block_x    = tfc_clamp10(tfc_mirror(col_ff, geom));
      place_in.block_y    = PosW'(row_ff) * PosW'(geom.rows_per_pixel);
      place_in.frame_done = frame_end;
      if (frame_end) begin
         place_in.hot_temp  = hv;
         place_in.hot_x     = tfc_clamp10(tfc_mirror(hc, geom) + half_w);
         place_in.hot_y     = PosW'(hr) * PosW'(geom.rows_per_pixel) + half_h;
         place_in.cold_temp = cv;
         place_in.cold_x    = tfc_clamp10(tfc_mirror(cc, geom) + half_w);
         place_in.cold_y    = PosW'(cr) * PosW'(geom.rows_per_pixel) + half_h;
      end

      hot_val_in  = hv;
      hot_col_in  = hc;
      hot_row_in  = hr;
      cold_val_in = cv;
      cold_col_in = cc;
      cold_row_in = cr;
      col_in      = col_ff + 1'b1;
      row_in      = row_ff;
      if (frame_end) begin
         hot_val_in  = TempMin;
         hot_col_in  = '0;
         hot_row_in  = '0;
         cold_val_in = TempMax;
         cold_col_in = '0;
         cold_row_in = '0;
         col_in      = '0;
         row_in      = '0;
      end else if (col_last) begin
         col_in = '0;
         row_in = row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         hot_val_ff  <= TempMin;
         hot_col_ff  <= '0;
         hot_row_ff  <= '0;
         cold_val_ff <= TempMax;
         cold_col_ff <= '0;
         cold_row_ff <= '0;
      end else if (advance) begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         hot_val_ff  <= hot_val_in;
         hot_col_ff  <= hot_col_in;
         hot_row_ff  <= hot_row_in;
         cold_val_ff <= cold_val_in;
         cold_col_ff <= cold_col_in;
         cold_row_ff <= cold_row_in;
      end
      if (advance) begin
         place_ff <= place_in;
      end
   end

   assign place = place_ff;

endmodule

/* sv/thermal_frame_false_colour_top.sv */
`timescale 1ns / 1ps
// Thermal false color: one sensor temperature in, one display color and block
// position out, in raster order of a 32 x 24 sensor frame.
// req_chan carries a signed 1/64 degree sample; rsp_chan carries RGB, the mirrored
// block origin and, on the frame's last sample, the hottest and coldest values with
// their marker centers. Both channels transfer when valid and ready are high together.
// The csr_ port writes one register per cycle when csr_we is high; write it only
// while no sample is in flight.
// A sample at or outside the limits goes straight to the color mix; a sample between
// them first passes through the 11-step restoring divider. The shared 16x9 brightness
// multiplier serves the three color components one after another. One sample is in
// flight at a time, so a new sample is taken only after the last one has been handed
// to the output register. req_chan.ready is high only while the sequencer is idle.
// A finished result waits in the output register; if rsp_chan is stalled, the next
// sample is still taken and is held before the output stage until the register frees.
// Synchronous reset restores the register defaults, clears the raster counters and
// the frame extremes, and drops any pending result.
module thermal_frame_false_colour_top import tfc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   tfc_req_if.sink             req_chan,
   tfc_rsp_if.source           rsp_chan,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   // Configuration registers
   logic signed [TempW-1:0] temp_low_ff, temp_high_ff;
   logic [BrightW-1:0]      brightness_ff;
   tfc_geom_type            geom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_low_ff            <= TempLowReset;
         temp_high_ff           <= TempHighReset;
         brightness_ff          <= BrightnessReset;
         geom_ff.cols_per_pixel <= BlockWidthReset;
         geom_ff.rows_per_pixel <= BlockHeightReset;
         geom_ff.screen_width   <= ScreenWidthReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEMP_LOW:     temp_low_ff            <= csr_wdata;
            CSR_TEMP_HIGH:    temp_high_ff           <= csr_wdata;
            CSR_BRIGHTNESS:   brightness_ff          <= csr_wdata[BrightW-1:0];
            CSR_BLOCK_WIDTH:  geom_ff.cols_per_pixel <= csr_wdata[BlockW-1:0];
            CSR_BLOCK_HEIGHT: geom_ff.rows_per_pixel <= csr_wdata[BlockW-1:0];
            CSR_SCREEN_WIDTH: geom_ff.screen_width   <= csr_wdata[ScreenW-1:0];
            default: ;
         endcase
      end
   end

   state_type          state_ff, state_in;
   logic [SegW-1:0]    seg_ff, seg_in;
   logic [BlendW-1:0]  blend_ff, blend_in;
   logic [1:0]         comp_ff, comp_in;
   logic [ColorW-1:0]  red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ColorW-1:0]  rsp_red_ff, rsp_red_in, rsp_green_ff, rsp_green_in;
   logic [ColorW-1:0]  rsp_blue_ff, rsp_blue_in;
   tfc_place_type      rsp_place_ff, rsp_place_in;

   logic               accept;
   logic signed [TempW:0] diff, span;
   logic               div_start, div_done;
   logic [NumW-1:0]    dividend;
   logic [QuotW-1:0]   quotient;
   tfc_place_type      place;

   logic               c1_on, c2_on;
   logic [MixW-1:0]    ramp, mix;
   logic [ProdW-1:0]   prod;
   logic [ColorW:0]    scaled;
   logic [ColorW-1:0]  level;

   assign accept = req_chan.valid && req_chan.ready;

   // Offset from the low limit and span of the limits, both exact
   assign diff     = 17'(req_chan.temperature) - 17'(temp_low_ff);
   assign span     = 17'(temp_high_ff) - 17'(temp_low_ff);
   assign dividend = {diff[DivisorW-1:0], 11'b0} - {3'b000, diff[DivisorW-1:0], 8'b0};

   tfc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (span[DivisorW-1:0]),
      .done     (div_done),
      .quotient (quotient)
   );

   tfc_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .temperature (req_chan.temperature),
      .geom        (geom_ff),
      .place       (place)
   );

   // Blend one component and scale it through the shared multiplier
   always_comb begin
      c1_on  = tfc_pal_on(seg_ff, comp_ff);
      c2_on  = tfc_pal_on(seg_ff + 1'b1, comp_ff);
      ramp   = {blend_ff, 8'b0} - {8'b0, blend_ff};
      case ({c1_on, c2_on})
         2'b00:   mix = '0;
         2'b01:   mix = ramp;
         2'b10:   mix = 16'hFF00 - ramp;
         default: mix = 16'hFF00;
      endcase
      prod   = ProdW'(mix) * ProdW'(brightness_ff);
      scaled = prod[ProdW-1:MixW];
      level  = scaled[ColorW] ? '1 : scaled[ColorW-1:0];
   end

   // Sequencer: classify, divide if between the limits, mix three components, hand off to the output register
   always_comb begin
      state_in     = state_ff;
      seg_in       = seg_ff;
      blend_in     = blend_ff;
      comp_in      = comp_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_place_in = rsp_place_ff;
      div_start    = 1'b0;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               comp_in  = COMP_RED;
               blend_in = '0;
               if (diff <= 0) begin
                  seg_in   = '0;
                  state_in = ST_MIX;
               end else if (diff >= span) begin
                  seg_in   = '1;
                  state_in = ST_MIX;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               seg_in   = quotient[QuotW-1:BlendW];
               blend_in = quotient[BlendW-1:0];
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            comp_in = comp_ff + 1'b1;
            case (comp_ff)
               COMP_RED:   red_in   = level;
               COMP_GREEN: green_in = level;
               default: begin
                  blue_in  = level;
                  state_in = ST_OUTPUT;
               end
            endcase
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_red_in   = red_ff;
               rsp_green_in = green_ff;
               rsp_blue_in  = blue_ff;
               rsp_place_in = place;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seg_ff       <= seg_in;
      blend_ff     <= blend_in;
      comp_ff      <= comp_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_place_ff <= rsp_place_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.red        = rsp_red_ff;
   assign rsp_chan.green      = rsp_green_ff;
   assign rsp_chan.blue       = rsp_blue_ff;
   assign rsp_chan.block_x    = rsp_place_ff.block_x;
   assign rsp_chan.block_y    = rsp_place_ff.block_y;
   assign rsp_chan.frame_done = rsp_place_ff.frame_done;
   assign rsp_chan.hot_temp   = rsp_place_ff.hot_temp;
   assign rsp_chan.hot_x      = rsp_place_ff.hot_x;
   assign rsp_chan.hot_y      = rsp_place_ff.hot_y;
   assign rsp_chan.cold_temp  = rsp_place_ff.cold_temp;
   assign rsp_chan.cold_x     = rsp_place_ff.cold_x;
   assign rsp_chan.cold_y     = rsp_place_ff.cold_y;

endmodule

/* sv/tfc_checker.sv */
`timescale 1ns / 1ps

module tfc_checker import tfc_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [ColorW-1:0]       rsp_red,
   input logic [ColorW-1:0]       rsp_green,
   input logic [ColorW-1:0]       rsp_blue,
   input logic                    rsp_frame_done,
   input logic signed [TempW-1:0] rsp_hot_temp,
   input logic signed [TempW-1:0] rsp_cold_temp,
   input logic [PosW-1:0]         rsp_hot_x,
   input logic [PosW-1:0]         rsp_cold_x
);

   // A taken sample keeps input ready low while the sequencer mixes the three color components
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("input ready returned before the color mix finished");

   // A stalled result holds its color
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
                                  && $stable(rsp_blue))
      else $error("stalled result changed");

   // Extreme temperatures and x positions are zero away from a frame end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_hot_temp == 0 && rsp_cold_temp == 0
                                       && rsp_hot_x == 0 && rsp_cold_x == 0)
      else $error("extremes reported outside a frame end");

   // The frame's hottest sample is never colder than its coldest
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_hot_temp >= rsp_cold_temp)
      else $error("hottest below coldest at frame end");

endmodule

bind thermal_frame_false_colour_top tfc_checker u_tfc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_red        (rsp_chan.red),
   .rsp_green      (rsp_chan.green),
   .rsp_blue       (rsp_chan.blue),
   .rsp_frame_done (rsp_chan.frame_done),
   .rsp_hot_temp   (rsp_chan.hot_temp),
   .rsp_cold_temp  (rsp_chan.cold_temp),
   .rsp_hot_x      (rsp_chan.hot_x),
   .rsp_cold_x     (rsp_chan.cold_x)
);
